// ===== rtl/core/spc_pkg.sv =====
`timescale 1ns / 1ps

package spc_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgOutputEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgChargePowerThr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgReleaseBufThr  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSavingBufThr   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHoldoffMs      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStartupMs      = 3'd5;

  // Register reset values
  localparam logic [15:0] ChargePowerThrRst = 16'd3200;
  localparam logic [15:0] ReleaseBufThrRst  = 16'd3200;
  localparam logic [15:0] SavingBufThrRst   = 16'd1280;
  localparam logic [7:0]  HoldoffMsRst      = 8'd18;
  localparam logic [15:0] StartupMsRst      = 16'd3000;

  // Operating modes of the power path
  typedef enum logic [1:0] {
    ModeCharge = 2'd0,
    ModeIdle   = 2'd1,
    ModeShared = 2'd2,
    ModeCap    = 2'd3
  } mode_e;

  // Input word: one measurement tick
  typedef struct packed {
    logic [15:0] load_power;
    logic [15:0] buffer_energy;
    logic [31:0] time_ms;
    logic        supply_lost;
  } in_word_t;

  // Result word: switch pattern, mode and discharge time after the tick
  typedef struct packed {
    logic        main_switch_on;
    logic        charge_switch_on;
    logic        discharge_switch_on;
    logic [1:0]  mode;
    logic [31:0] discharge_time;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic        output_enable;
    logic [15:0] charge_power_threshold;
    logic [15:0] release_buffer_threshold;
    logic [15:0] saving_buffer_threshold;
    logic [7:0]  holdoff_ms;
    logic [15:0] startup_ms;
  } cfg_t;

endpackage

// ===== rtl/core/supercap_power_path_controller_top.sv =====
`timescale 1ns / 1ps

// Supercapacitor power-path controller.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one measurement
// word per tick: load power, buffer energy, millisecond timestamp and the
// supply-lost flag. Output channel (out_valid_o / out_stall_i / out_data_o)
// returns exactly one word per input word: the three switch states, the mode
// and the discharge-time counter, all after that tick's update.
// A word passes through the input register, then the mode logic feeding the
// result register. Throughput is one word per cycle while the receiver does
// not stall; the input register and the result register each hold a word,
// so the input side takes one more word while a finished word waits at the
// output. When the receiver stalls, the result word holds; a second word
// waits in the input register and only then is in_stall_o raised.
// Reset clears both valid flags, puts the machine in charge mode with all
// switches off and the counter at zero, and loads the register defaults.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// next edge; indexes beyond the register list are ignored.

module supercap_power_path_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  spc_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output spc_pkg::out_word_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [spc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [spc_pkg::CfgDataW-1:0]      cfg_data_i
);

  spc_pkg::cfg_t      cfg_q;
  spc_pkg::in_word_t  in_word_q;
  spc_pkg::out_word_t out_word_q;
  spc_pkg::out_word_t result;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               step;
  logic               in_take;

  // Move the input word on when the result register is free or being drained
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_enable            <= 1'b0;
      cfg_q.charge_power_threshold   <= spc_pkg::ChargePowerThrRst;
      cfg_q.release_buffer_threshold <= spc_pkg::ReleaseBufThrRst;
      cfg_q.saving_buffer_threshold  <= spc_pkg::SavingBufThrRst;
      cfg_q.holdoff_ms               <= spc_pkg::HoldoffMsRst;
      cfg_q.startup_ms               <= spc_pkg::StartupMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spc_pkg::CfgOutputEnable:   cfg_q.output_enable            <= cfg_data_i[0];
        spc_pkg::CfgChargePowerThr: cfg_q.charge_power_threshold   <= cfg_data_i;
        spc_pkg::CfgReleaseBufThr:  cfg_q.release_buffer_threshold <= cfg_data_i;
        spc_pkg::CfgSavingBufThr:   cfg_q.saving_buffer_threshold  <= cfg_data_i;
        spc_pkg::CfgHoldoffMs:      cfg_q.holdoff_ms               <= cfg_data_i[7:0];
        spc_pkg::CfgStartupMs:      cfg_q.startup_ms               <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Valid flags of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_data_i;
    end
    if (step) begin
      out_word_q <= result;
    end
  end

  spc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .word_i   (in_word_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // Charging is only ever done with the main path on
  a_charge_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.charge_switch_on |-> out_data_o.main_switch_on)
    else $error("charge switch on without main switch");

  // Stall only while the input register holds a word
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // A processed word always shows up at the output
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o && (out_data_o == $past(result)))
    else $error("processed word not presented");

endmodule

// ===== rtl/core/spc_ctrl.sv =====
`timescale 1ns / 1ps

module spc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  spc_pkg::cfg_t    cfg_i,
  input  spc_pkg::in_word_t  word_i,
  output spc_pkg::out_word_t result_o
);

  spc_pkg::mode_e mode_q, mode_d;
  logic        main_sw_q, main_sw_d;
  logic        charge_sw_q, charge_sw_d;
  logic        dis_sw_q, dis_sw_d;
  logic [31:0] cap_stamp_q, cap_stamp_d;
  logic [31:0] main_stamp_q, main_stamp_d;
  logic [31:0] count_q, count_d;

  logic        run;
  logic        main_elapsed;
  logic        cap_elapsed;
  logic [31:0] main_diff;
  logic [31:0] cap_diff;
  logic [31:0] holdoff_ext;

  // Wrap-safe elapsed time against the holdoff
  assign holdoff_ext  = {24'd0, cfg_i.holdoff_ms};
  assign main_diff    = word_i.time_ms - main_stamp_q;
  assign cap_diff     = word_i.time_ms - cap_stamp_q;
  assign main_elapsed = main_diff > holdoff_ext;
  assign cap_elapsed  = cap_diff > holdoff_ext;

  // Run the machine only after startup and with the supply link present
  assign run = !word_i.supply_lost && (word_i.time_ms > {16'd0, cfg_i.startup_ms});

  // Next state for one tick; later mode tests win
  always_comb begin
    mode_d       = mode_q;
    main_sw_d    = main_sw_q;
    charge_sw_d  = charge_sw_q;
    dis_sw_d     = dis_sw_q;
    cap_stamp_d  = cap_stamp_q;
    main_stamp_d = main_stamp_q;
    count_d      = count_q;
    if (run) begin
      unique case (mode_q)
        spc_pkg::ModeCharge: begin
          if ((count_q != 32'd0) && !word_i.time_ms[0]) begin
            count_d = count_q - 32'd1;
          end
          main_sw_d   = 1'b1;
          charge_sw_d = 1'b1;
          if (main_elapsed) begin
            dis_sw_d = 1'b0;
          end
          if (word_i.load_power > cfg_i.charge_power_threshold) begin
            mode_d = spc_pkg::ModeIdle;
          end
          if (word_i.buffer_energy < cfg_i.release_buffer_threshold) begin
            mode_d = spc_pkg::ModeShared;
          end
        end
        spc_pkg::ModeIdle: begin
          main_sw_d   = 1'b1;
          charge_sw_d = 1'b0;
          if (main_elapsed) begin
            dis_sw_d = 1'b0;
          end
          if (word_i.load_power < cfg_i.charge_power_threshold) begin
            mode_d = spc_pkg::ModeCharge;
          end
          if (word_i.buffer_energy < cfg_i.release_buffer_threshold) begin
            mode_d      = spc_pkg::ModeShared;
            cap_stamp_d = word_i.time_ms;
          end
        end
        spc_pkg::ModeShared: begin
          main_sw_d   = 1'b1;
          charge_sw_d = 1'b0;
          if (cfg_i.output_enable) begin
            dis_sw_d = 1'b1;
          end else if (main_elapsed) begin
            dis_sw_d = 1'b0;
          end
          if (word_i.buffer_energy > cfg_i.release_buffer_threshold) begin
            mode_d = spc_pkg::ModeIdle;
          end
          if ((word_i.buffer_energy < cfg_i.saving_buffer_threshold) && cap_elapsed &&
              cfg_i.output_enable) begin
            mode_d = spc_pkg::ModeCap;
          end
        end
        spc_pkg::ModeCap: begin
          if (count_q != 32'hFFFF_FFFF) begin
            count_d = count_q + 32'd1;
          end
          main_sw_d   = 1'b0;
          charge_sw_d = 1'b0;
          dis_sw_d    = 1'b1;
          if ((word_i.buffer_energy > cfg_i.release_buffer_threshold) ||
              !cfg_i.output_enable) begin
            main_stamp_d = word_i.time_ms;
            mode_d       = spc_pkg::ModeShared;
          end
        end
        default: begin
          mode_d = spc_pkg::ModeCharge;
        end
      endcase
    end else begin
      // Safe pattern: main and discharge on, mode and counter held
      main_sw_d   = 1'b1;
      charge_sw_d = 1'b0;
      dis_sw_d    = 1'b1;
    end
  end

  // Result carries the values after this tick
  always_comb begin
    result_o.main_switch_on      = main_sw_d;
    result_o.charge_switch_on    = charge_sw_d;
    result_o.discharge_switch_on = dis_sw_d;
    result_o.mode                = mode_d;
    result_o.discharge_time      = count_d;
  end

  // Hold state; advance on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= spc_pkg::ModeCharge;
      main_sw_q    <= 1'b0;
      charge_sw_q  <= 1'b0;
      dis_sw_q     <= 1'b0;
      cap_stamp_q  <= 32'd0;
      main_stamp_q <= 32'd0;
      count_q      <= 32'd0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      main_sw_q    <= main_sw_d;
      charge_sw_q  <= charge_sw_d;
      dis_sw_q     <= dis_sw_d;
      cap_stamp_q  <= cap_stamp_d;
      main_stamp_q <= main_stamp_d;
      count_q      <= count_d;
    end
  end

endmodule
